@@ hw/rtl/pcmac_pkg.sv @@
// ----------------------------------------------------------------------------
// pcmac_pkg
// Types and codes shared by the pixel cache multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmac_pkg;

  // bus function codes
  localparam logic [2:0] FUNC_BYTE_WR  = 3'd0;
  localparam logic [2:0] FUNC_CTRL_WR  = 3'd1;
  localparam logic [2:0] FUNC_ACCUM    = 3'd2;
  localparam logic [2:0] FUNC_CLEAR    = 3'd3;
  localparam logic [2:0] FUNC_FILL     = 3'd4;
  localparam logic [2:0] FUNC_CACHE_WR = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_FOUR_BIT   = 2'd0;
  localparam logic [1:0] CFG_FILL_EN    = 2'd1;
  localparam logic [1:0] CFG_BYTE_CYCLE = 2'd2;

  // control byte bit positions
  localparam int unsigned CTRL_PAIR_WRAP = 0;
  localparam int unsigned CTRL_HALF_PTR  = 1;
  localparam int unsigned CTRL_PTR_LO    = 2;
  localparam int unsigned CTRL_MUL_EN    = 4;
  localparam int unsigned CTRL_SUB_EN    = 5;
  localparam int unsigned CTRL_ACCUM     = 6;
  localparam int unsigned CTRL_CLEAR     = 7;

  // nibble masks
  localparam logic [7:0] NIB_HI_MASK = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0f;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] byte_sel;
    logic [7:0] data;
  } pcmac_in_t;

  typedef struct packed {
    logic        [31:0] write_word;
    logic signed [31:0] accumulator;
    logic        [1:0]  cache_pointer;
    logic               nibble_pointer;
  } pcmac_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/pixel_cache_multiply_accumulate.sv @@
// ----------------------------------------------------------------------------
// pixel_cache_multiply_accumulate
// Throughput: one transaction per cycle unless in_stall_o is high; a two-entry
//   output stage (result register plus skid register) keeps input open while
//   a result waits. Each accepted transaction's result is registered there.
// The 16x16 signed multiply and 32-bit add are combinational.
// Reset (rst_ni low, async): cache, pointers, flags, accumulator and config
//   clear to zero; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_cache_multiply_accumulate (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // item input
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire pcmac_pkg::pcmac_in_t in_data_i,
  // result output
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output pcmac_pkg::pcmac_out_t  out_data_o,
  // configuration writes
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [1:0]             cfg_index_i,
  input  wire                    cfg_wdata_i
);
  import pcmac_pkg::*;

  // configuration registers
  logic four_bit_q, fill_en_q, byte_cycle_q;

  // block state
  logic [7:0]  cache_q [4];
  logic [7:0]  cache_d [4];
  logic [1:0]  bptr_q, bptr_d;
  logic        half_q, half_d;
  logic        pair_q, pair_d;
  logic        mul_q, mul_d;
  logic        sub_q, sub_d;
  logic [31:0] acc_q, acc_d;

  // output stage
  logic       out_vld_q, skid_vld_q;
  pcmac_out_t out_q, skid_q, res;

  logic accept, out_fire;
  logic signed [15:0] half_lo, half_hi;
  logic signed [31:0] prod;
  logic        sub_sel;
  logic [31:0] acc_comb;
  logic [7:0]  cur_byte;
  logic [31:0] word;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_vld_q;
  assign accept      = in_valid_i && !skid_vld_q;
  assign out_fire    = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q   <= 1'b0;
      fill_en_q    <= 1'b0;
      byte_cycle_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FOUR_BIT:   four_bit_q   <= cfg_wdata_i;
        CFG_FILL_EN:    fill_en_q    <= cfg_wdata_i;
        CFG_BYTE_CYCLE: byte_cycle_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // signed product of the two cache halves
  assign half_lo  = {cache_q[1], cache_q[0]};
  assign half_hi  = {cache_q[3], cache_q[2]};
  assign prod     = half_lo * half_hi;
  assign sub_sel  = (in_data_i.func == FUNC_CTRL_WR) ? in_data_i.data[CTRL_SUB_EN] : sub_q;
  assign acc_comb = sub_sel ? (acc_q - prod) : (acc_q + prod);
  assign cur_byte = cache_q[bptr_q];

  // next state and result word
  always_comb begin
    cache_d = cache_q;
    bptr_d  = bptr_q;
    half_d  = half_q;
    pair_d  = pair_q;
    mul_d   = mul_q;
    sub_d   = sub_q;
    acc_d   = acc_q;
    word    = 32'd0;
    case (in_data_i.func)
      FUNC_BYTE_WR: begin
        cache_d[in_data_i.byte_sel] = in_data_i.data;
      end
      FUNC_CTRL_WR: begin
        pair_d = in_data_i.data[CTRL_PAIR_WRAP];
        half_d = in_data_i.data[CTRL_HALF_PTR];
        bptr_d = in_data_i.data[CTRL_PTR_LO +: 2];
        mul_d  = in_data_i.data[CTRL_MUL_EN];
        sub_d  = in_data_i.data[CTRL_SUB_EN];
        if (in_data_i.data[CTRL_ACCUM]) acc_d = acc_comb;
        if (in_data_i.data[CTRL_CLEAR]) acc_d = 32'd0;
      end
      FUNC_ACCUM: begin
        acc_d = acc_comb;
      end
      FUNC_CLEAR: begin
        acc_d = 32'd0;
      end
      FUNC_FILL: begin
        if (fill_en_q) begin
          if (four_bit_q) begin
            if (half_q) begin
              cache_d[bptr_q] = (cur_byte & NIB_HI_MASK) | (in_data_i.data & NIB_LO_MASK);
              half_d = 1'b0;
              bptr_d = bptr_q + 2'd1;
            end else begin
              cache_d[bptr_q] = (cur_byte & NIB_LO_MASK) | (in_data_i.data & NIB_HI_MASK);
              half_d = 1'b1;
            end
          end else begin
            cache_d[bptr_q] = in_data_i.data;
            if (pair_q) bptr_d = {bptr_q[1], ~bptr_q[0]};
            else        bptr_d = bptr_q + 2'd1;
          end
        end
      end
      FUNC_CACHE_WR: begin
        if (byte_cycle_q)  word = {4{cur_byte}};
        else if (mul_q)    word = acc_comb;
        else               word = {cache_q[3], cache_q[2], cache_q[1], cache_q[0]};
      end
      default: ;
    endcase
    res.write_word     = word;
    res.accumulator    = acc_d;
    res.cache_pointer  = bptr_d;
    res.nibble_pointer = half_d;
  end

  // state update on accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_q <= '{default: 8'd0};
      bptr_q  <= 2'd0;
      half_q  <= 1'b0;
      pair_q  <= 1'b0;
      mul_q   <= 1'b0;
      sub_q   <= 1'b0;
      acc_q   <= 32'd0;
    end else if (accept) begin
      cache_q <= cache_d;
      bptr_q  <= bptr_d;
      half_q  <= half_d;
      pair_q  <= pair_d;
      mul_q   <= mul_d;
      sub_q   <= sub_d;
      acc_q   <= acc_d;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) skid_vld_q <= 1'b0;
    end else if (accept) begin
      if (!out_vld_q || out_fire) out_vld_q <= 1'b1;
      else                        skid_vld_q <= 1'b1;
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (accept) begin
      if (!out_vld_q || out_fire) out_q  <= res;
      else                        skid_q <= res;
    end
  end

  // skid entry only holds data behind a pending result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without pending result");

  // skid fills only when the result register was stalled
  a_skid_fill_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled while result register was free");

  // clear transaction zeroes the accumulator
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.func == FUNC_CLEAR) |=> (acc_q == 32'd0))
    else $error("accumulator not cleared");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel cache multiply-accumulate block. It drives
// bus transactions with random gaps and output stalls. An in-bench model
// predicts each result, and every result is compared field by field in
// arrival order. A directed prologue covers the edge cases, and phases of
// random traffic follow, each under its own configuration.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmac_pkg::*;

  // function codes the block does not use
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned NUM_PHASES   = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall_o;
  pcmac_in_t  in_data;
  logic       out_valid_o;
  logic       out_stall;
  pcmac_out_t out_data_o;
  logic       cfg_valid;
  logic       cfg_ready_o;
  logic [1:0] cfg_index;
  logic       cfg_wdata;
  bit         idle_on;

  pixel_cache_multiply_accumulate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // mac state mirror and queue of predicted results
  class mac_scoreboard;
    logic [7:0]   cache [4];
    logic [1:0]   byte_ptr;
    logic         half_ptr;
    logic         pair_wrap;
    logic         mul_en;
    logic         sub_en;
    logic [31:0]  acc;
    logic         four_bit;
    logic         fill_en;
    logic         byte_cycle;
    pcmac_out_t   expected_results[$];
    int unsigned  errors;
    int unsigned  shown;

    function new();
      foreach (cache[i]) cache[i] = '0;
      byte_ptr   = '0;
      half_ptr   = 1'b0;
      pair_wrap  = 1'b0;
      mul_en     = 1'b0;
      sub_en     = 1'b0;
      acc        = '0;
      four_bit   = 1'b0;
      fill_en    = 1'b0;
      byte_cycle = 1'b0;
      errors     = 0;
      shown      = 0;
    endfunction

    // accumulator plus or minus the product of the two signed cache halves
    function logic [31:0] mac_sum();
      logic signed [15:0] lo_half;
      logic signed [15:0] hi_half;
      logic signed [31:0] prod;
      lo_half = {cache[1], cache[0]};
      hi_half = {cache[3], cache[2]};
      prod    = lo_half * hi_half;
      return sub_en ? acc - prod : acc + prod;
    endfunction

    function void write_reg(logic [1:0] idx, logic val);
      case (idx)
        CFG_FOUR_BIT:   four_bit   = val;
        CFG_FILL_EN:    fill_en    = val;
        CFG_BYTE_CYCLE: byte_cycle = val;
        default: ;
      endcase
    endfunction

    // apply one accepted input transaction and queue its result
    function void note_item(pcmac_in_t it);
      pcmac_out_t res;
      logic [7:0] cur;
      res = '0;
      cur = cache[byte_ptr];
      case (it.func)
        FUNC_BYTE_WR: cache[it.byte_sel] = it.data;
        FUNC_CTRL_WR: begin
          pair_wrap = it.data[CTRL_PAIR_WRAP];
          half_ptr  = it.data[CTRL_HALF_PTR];
          byte_ptr  = it.data[CTRL_PTR_LO +: 2];
          mul_en    = it.data[CTRL_MUL_EN];
          sub_en    = it.data[CTRL_SUB_EN];
          if (it.data[CTRL_ACCUM]) acc = mac_sum();
          if (it.data[CTRL_CLEAR]) acc = '0;
        end
        FUNC_ACCUM: acc = mac_sum();
        FUNC_CLEAR: acc = '0;
        FUNC_FILL: begin
          if (fill_en) begin
            if (four_bit) begin
              // nibble fill always wraps over all four bytes
              if (half_ptr) begin
                cache[byte_ptr] = (cur & NIB_HI_MASK) | (it.data & NIB_LO_MASK);
                half_ptr = 1'b0;
                byte_ptr = byte_ptr + 2'd1;
              end else begin
                cache[byte_ptr] = (cur & NIB_LO_MASK) | (it.data & NIB_HI_MASK);
                half_ptr = 1'b1;
              end
            end else begin
              cache[byte_ptr] = it.data;
              if (pair_wrap) byte_ptr = {byte_ptr[1], ~byte_ptr[0]};
              else byte_ptr = byte_ptr + 2'd1;
            end
          end
        end
        FUNC_CACHE_WR: begin
          if (byte_cycle) res.write_word = {4{cur}};
          else if (mul_en) res.write_word = mac_sum();
          else res.write_word = {cache[3], cache[2], cache[1], cache[0]};
        end
        default: ;
      endcase
      res.accumulator    = acc;
      res.cache_pointer  = byte_ptr;
      res.nibble_pointer = half_ptr;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $time);
        end
      end
    endfunction

    function void check_result(pcmac_out_t got);
      pcmac_out_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("result with nothing expected: %h at %0t", got, $time);
        end
        return;
      end
      want = expected_results.pop_front();
      compare_field("write_word", want.write_word, got.write_word);
      compare_field("accumulator", want.accumulator, got.accumulator);
      compare_field("cache_pointer", 32'(want.cache_pointer), 32'(got.cache_pointer));
      compare_field("nibble_pointer", 32'(want.nibble_pointer), 32'(got.nibble_pointer));
    endfunction
  endclass

  mac_scoreboard sb;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_item(in_data);
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
    end
  end

  // output back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && idle_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  function automatic pcmac_in_t pack_item(logic [2:0] f, logic [1:0] s, logic [7:0] d);
    pcmac_in_t it;
    it.func     = f;
    it.byte_sel = s;
    it.data     = d;
    return it;
  endfunction

  // one input transaction, called and returning at a falling edge
  task automatic send_item(pcmac_in_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send(logic [2:0] f, logic [1:0] s, logic [7:0] d);
    send_item(pack_item(f, s, d));
  endtask

  // hold off input until every predicted result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic four, logic fill, logic cycle);
    drain();
    repeat (2) @(negedge clk_i);
    write_reg(CFG_FOUR_BIT, four);
    write_reg(CFG_FILL_EN, fill);
    write_reg(CFG_BYTE_CYCLE, cycle);
  endtask

  // weighted random transaction, fill and multiply traffic favored
  function automatic pcmac_in_t random_item();
    int unsigned r;
    logic [2:0]  f;
    logic [7:0]  d;
    logic [7:0]  extremes [4];
    extremes = '{8'h00, 8'h7f, 8'h80, 8'hff};
    r = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    if (r < 14) f = FUNC_BYTE_WR;
    else if (r < 28) f = FUNC_CTRL_WR;
    else if (r < 42) f = FUNC_ACCUM;
    else if (r < 46) f = FUNC_CLEAR;
    else if (r < 74) f = FUNC_FILL;
    else if (r < 94) f = FUNC_CACHE_WR;
    else if (r < 97) f = FUNC_SPARE_6;
    else f = FUNC_SPARE_7;
    // keep the accumulator from being wiped by most control writes
    if (f == FUNC_CTRL_WR && $urandom_range(0, 7) != 0) d[CTRL_CLEAR] = 1'b0;
    if ((f == FUNC_BYTE_WR || f == FUNC_FILL) && $urandom_range(0, 3) == 0)
      d = extremes[2'($urandom_range(0, 3))];
    return pack_item(f, 2'($urandom_range(0, 3)), d);
  endfunction

  // run limit
  initial begin
    #5_000_000;
    $display("[pixel_cache_multiply_accumulate] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FOUR_BIT;
    cfg_wdata = 1'b0;
    idle_on   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    idle_on = 1'b1;

    // most negative halves, product overflow on second accumulate
    set_config(1'b0, 1'b0, 1'b0);
    send(FUNC_BYTE_WR, 2'd0, 8'h00);
    send(FUNC_BYTE_WR, 2'd1, 8'h80);
    send(FUNC_BYTE_WR, 2'd2, 8'h00);
    send(FUNC_BYTE_WR, 2'd3, 8'h80);
    send(FUNC_ACCUM, 2'd0, 8'h00);
    send(FUNC_ACCUM, 2'd0, 8'h00);
    send(FUNC_CACHE_WR, 2'd0, 8'h00);
    send(FUNC_CTRL_WR, 2'd0, 8'h10);
    send(FUNC_CACHE_WR, 2'd0, 8'h00);
    send(FUNC_CTRL_WR, 2'd0, 8'h70);
    send(FUNC_CTRL_WR, 2'd3, 8'hff);
    send(FUNC_CLEAR, 2'd0, 8'h00);
    send(FUNC_FILL, 2'd1, 8'ha5);
    send(FUNC_SPARE_6, 2'd3, 8'hff);
    send(FUNC_SPARE_7, 2'd0, 8'h00);
    send(FUNC_BYTE_WR, 2'd0, 8'hff);
    send(FUNC_BYTE_WR, 2'd1, 8'h7f);
    send(FUNC_ACCUM, 2'd0, 8'h00);

    // nibble fill, pair wrap ignored, pointer wraps from byte 3
    set_config(1'b1, 1'b1, 1'b0);
    send(FUNC_CTRL_WR, 2'd0, 8'h0f);
    send(FUNC_FILL, 2'd0, 8'h5a);
    send(FUNC_FILL, 2'd0, 8'hc3);
    send(FUNC_FILL, 2'd0, 8'h3c);

    // byte fill within a pair, then byte replication on cache write
    set_config(1'b0, 1'b1, 1'b1);
    send(FUNC_CTRL_WR, 2'd0, 8'h05);
    send(FUNC_FILL, 2'd0, 8'h11);
    send(FUNC_FILL, 2'd0, 8'h22);
    send(FUNC_CACHE_WR, 2'd0, 8'h00);

    // random phases, each under a fresh configuration
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) set_config(1'b1, 1'b1, 1'b1);
      else if (ph == 1) set_config(1'b0, 1'b0, 1'b0);
      else set_config(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 2) == 0);
      idle_on = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[pixel_cache_multiply_accumulate] OK");
    end else begin
      $display("[pixel_cache_multiply_accumulate] ERROR");
    end
    $finish;
  end

endmodule
